[hw/rtl/dirty_tile_map_marker_macros.svh]
// Assertion macros used by the checker.
`ifndef DIRTY_TILE_MAP_MARKER_MACROS_SVH
`define DIRTY_TILE_MAP_MARKER_MACROS_SVH

// Check a property at every clock edge outside reset.
`define TMM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("dirty_tile_map_marker: assertion failed");

// Check a property at every clock edge, reset included.
`define TMM_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("dirty_tile_map_marker: reset assertion failed");

`endif

[hw/rtl/tmm_pkg.sv]
package tmm_pkg;

    // Map geometry
    localparam int TILES_WIDE  = 32;
    localparam int TILES_HIGH  = 16;
    localparam int BLOCK_SHIFT = 4;

    // Field widths fixed by the item format
    localparam int COORD_W    = 16;
    localparam int TILE_COL_W = 5;
    localparam int TILE_ROW_W = 4;

    // Index widths into the map
    localparam int COL_W = (TILES_WIDE > 1) ? $clog2(TILES_WIDE) : 1;
    localparam int ROW_W = (TILES_HIGH > 1) ? $clog2(TILES_HIGH) : 1;

    // Map limits as signed tile coordinates
    localparam logic signed [COORD_W-1:0] TILES_WIDE_S = COORD_W'(TILES_WIDE);
    localparam logic signed [COORD_W-1:0] TILES_HIGH_S = COORD_W'(TILES_HIGH);

    // Item kinds
    localparam logic KIND_MARK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] top_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] bottom_y;
        logic [TILE_COL_W-1:0]     tile_col;
        logic [TILE_ROW_W-1:0]     tile_row;
    } item_t;

    typedef struct packed {
        logic accepted;
        logic tile_marked;
    } result_t;

    // Clipped rectangle in tile units
    typedef struct packed {
        logic                  hit;
        logic                  empty;
        logic [ROW_W-1:0]      row_first;
        logic [ROW_W-1:0]      row_last;
        logic [TILES_WIDE-1:0] mask;
    } rect_t;

    // Access to the tile map memory
    typedef struct packed {
        logic                  rd_en;
        logic [ROW_W-1:0]      rd_addr;
        logic                  wr_en;
        logic [ROW_W-1:0]      wr_addr;
        logic [TILES_WIDE-1:0] wr_data;
    } map_req_t;

endpackage

[hw/rtl/tmm_ram.sv]
module tmm_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                           wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                           rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/tmm_map.sv]
module tmm_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tmm_pkg::map_req_t                 req,
    output logic [tmm_pkg::TILES_WIDE-1:0]    rd_data
);
    import tmm_pkg::*;

    logic [TILES_HIGH-1:0] valid_reg;
    logic [TILES_HIGH-1:0] valid_next;
    logic                  rd_valid_reg;
    logic [TILES_WIDE-1:0] ram_data;

    tmm_ram #(
        .DATA_W (TILES_WIDE),
        .DEPTH  (TILES_HIGH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_data)
    );

    // Mark a row valid once it has been written
    always_comb begin
        valid_next = valid_reg;
        if (req.wr_en) begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    // Clear all rows at reset; capture row validity alongside the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // A row never written reads as cleared
    assign rd_data = rd_valid_reg ? ram_data : '0;

endmodule

[hw/rtl/tmm_rect.sv]
module tmm_rect (
    input  tmm_pkg::item_t item,
    output tmm_pkg::rect_t rect
);
    import tmm_pkg::*;

    logic signed [COORD_W-1:0] xt1;
    logic signed [COORD_W-1:0] yt1;
    logic signed [COORD_W-1:0] xt2;
    logic signed [COORD_W-1:0] yt2;
    logic [COL_W-1:0]          x1;
    logic [COL_W-1:0]          x2;
    logic [ROW_W-1:0]          y1;
    logic [ROW_W-1:0]          y2;

    // Shift pixel corners down to tile units, rounding toward minus infinity
    assign xt1 = item.left_x   >>> BLOCK_SHIFT;
    assign yt1 = item.top_y    >>> BLOCK_SHIFT;
    assign xt2 = item.right_x  >>> BLOCK_SHIFT;
    assign yt2 = item.bottom_y >>> BLOCK_SHIFT;

    // Clip the corners to the map
    assign x1 = xt1[COORD_W-1] ? '0 : xt1[COL_W-1:0];
    assign y1 = yt1[COORD_W-1] ? '0 : yt1[ROW_W-1:0];
    assign x2 = (xt2 >= TILES_WIDE_S) ? COL_W'(TILES_WIDE - 1) : xt2[COL_W-1:0];
    assign y2 = (yt2 >= TILES_HIGH_S) ? ROW_W'(TILES_HIGH - 1) : yt2[ROW_W-1:0];

    // Reject a rectangle wholly off the map, build the column mask
    always_comb begin
        rect.hit = !((xt1 >= TILES_WIDE_S) || (yt1 >= TILES_HIGH_S)
                     || xt2[COORD_W-1] || yt2[COORD_W-1]);
        rect.empty     = (x1 > x2) || (y1 > y2);
        rect.row_first = y1;
        rect.row_last  = y2;
        for (int i = 0; i < TILES_WIDE; i++) begin
            rect.mask[i] = (COL_W'(i) >= x1) && (COL_W'(i) <= x2);
        end
    end

endmodule

[hw/rtl/dirty_tile_map_marker.sv]
// A mark walks its rows in ST_MARK and drains the last write in ST_MARK_LAST; a read
// passes ST_RD and ST_RD_CLR; a rejected or empty mark or an off-map read skips them.
// Each item then waits in ST_DONE until the output register is free. One item at a
// time; the row memory has separate read and write ports, one row word per cycle.
// Reset (aresetn, synchronous, active low) clears the tile map at once and drops any
// pending result; the block is ready in the first cycle after reset.
module dirty_tile_map_marker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tmm_pkg::item_t   s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output tmm_pkg::result_t m_item
);
    import tmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_MARK_LAST,
        ST_RD,
        ST_RD_CLR,
        ST_DONE
    } state_t;

    state_t                state_reg,    state_next;
    logic [ROW_W-1:0]      row_reg,      row_next;
    logic [ROW_W-1:0]      row_last_reg, row_last_next;
    logic [COL_W-1:0]      col_reg,      col_next;
    logic [TILES_WIDE-1:0] mask_reg,     mask_next;
    logic                  wr_pend_reg,  wr_pend_next;
    logic [ROW_W-1:0]      wr_row_reg,   wr_row_next;
    result_t               res_reg,      res_next;
    logic                  m_valid_reg,  m_valid_next;
    result_t               m_item_reg,   m_item_next;

    rect_t                 rect;
    map_req_t              map_req;
    logic [TILES_WIDE-1:0] map_data;
    logic                  s_accept;
    logic                  rd_in_map;

    tmm_rect u_rect (
        .item (s_item),
        .rect (rect)
    );

    tmm_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req),
        .rd_data (map_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign rd_in_map = (int'(s_item.tile_col) < TILES_WIDE)
                       && (int'(s_item.tile_row) < TILES_HIGH);

    // Sequence one item: decode, walk rows, read-modify-write, deliver
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        row_last_next = row_last_reg;
        col_next      = col_reg;
        mask_next     = mask_reg;
        wr_pend_next  = wr_pend_reg;
        wr_row_next   = wr_row_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        map_req       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_next   = '0;
                    state_next = ST_DONE;
                    if (s_item.kind == KIND_READ) begin
                        if (rd_in_map) begin
                            row_next   = ROW_W'(s_item.tile_row);
                            col_next   = COL_W'(s_item.tile_col);
                            state_next = ST_RD;
                        end
                    end else if (rect.hit) begin
                        res_next.accepted = 1'b1;
                        if (!rect.empty) begin
                            row_next      = rect.row_first;
                            row_last_next = rect.row_last;
                            mask_next     = rect.mask;
                            state_next    = ST_MARK;
                        end
                    end
                end
            end
            ST_MARK: begin
                // Read this row, write back the row read in the previous cycle
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = row_reg;
                if (wr_pend_reg) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = wr_row_reg;
                    map_req.wr_data = map_data | mask_reg;
                end
                wr_pend_next = 1'b1;
                wr_row_next  = row_reg;
                if (row_reg == row_last_reg) begin
                    state_next = ST_MARK_LAST;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_MARK_LAST: begin
                // Drain the last row write before the next item may read
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = wr_row_reg;
                map_req.wr_data = map_data | mask_reg;
                wr_pend_next    = 1'b0;
                state_next      = ST_DONE;
            end
            ST_RD: begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = row_reg;
                state_next      = ST_RD_CLR;
            end
            ST_RD_CLR: begin
                // Return the tile bit and clear it
                map_req.wr_en        = 1'b1;
                map_req.wr_addr      = row_reg;
                map_req.wr_data      = map_data & ~(TILES_WIDE'(1) << col_reg);
                res_next.tile_marked = map_data[col_reg];
                state_next           = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            row_last_reg <= row_last_next;
            col_reg      <= col_next;
            mask_reg     <= mask_next;
            wr_pend_reg  <= wr_pend_next;
            wr_row_reg   <= wr_row_next;
            res_reg      <= res_next;
            m_valid_reg  <= m_valid_next;
            m_item_reg   <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[hw/rtl/tmm_checker.sv]
`include "dirty_tile_map_marker_macros.svh"

module tmm_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input tmm_pkg::item_t   s_item,
    input logic             m_valid,
    input logic             m_ready,
    input tmm_pkg::result_t m_item
);
    import tmm_pkg::*;

    // Leave reset ready with no result shown
    `TMM_ASSERT_RST(a_reset_idle, !aresetn |=> (s_ready && !m_valid))

    // Take one item at a time
    `TMM_ASSERT(a_busy_after_item, (s_valid && s_ready) |=> !s_ready)

    // An item never yields a result in the cycle right after acceptance
    `TMM_ASSERT(a_no_instant_result, (s_valid && s_ready && !m_valid) |=> !m_valid)

    // A result never carries both the mark flag and the read flag
    `TMM_ASSERT(a_one_flag, m_valid |-> !(m_item.accepted && m_item.tile_marked))

    // Hold a stalled result
    `TMM_ASSERT(a_result_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))

endmodule

bind dirty_tile_map_marker tmm_checker u_tmm_checker (.*);
